/* rtl/core/bfsa_pkg.sv */
// Shared types and constants for the best-fit slot allocator.
package bfsa_pkg;

	localparam int MAX_SLOTS = 64;
	localparam int SLOT_W    = $clog2(MAX_SLOTS);
	localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
	localparam int BYTE_W    = 40;
	localparam int SIZE_W    = BYTE_W + 1;
	localparam int SUM_W     = BYTE_W + 2;
	localparam int OP_W      = 31;
	localparam int NUM_W     = 6;
	localparam int ALIGN_W   = 8;

	typedef enum logic [1:0] {
		CMD_ALLOC    = 2'd0,
		CMD_RELEASE  = 2'd1,
		CMD_FREE_ALL = 2'd2,
		CMD_NOP      = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_OOM  = 2'd1,
		ST_FULL = 2'd2,
		ST_RSVD = 2'd3
	} status_t;

	typedef struct packed {
		cmd_t              command;
		logic [BYTE_W-1:0] request_bytes;
		logic [OP_W-1:0]   operation_id;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [BYTE_W-1:0] slot_offset;
		logic [NUM_W-1:0]  slot_number;
		logic              was_reused;
		logic [BYTE_W-1:0] bytes_used;
		logic [BYTE_W-1:0] bytes_peak;
	} rsp_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;
		logic scan;
		logic fetch;
		logic grant;
		logic sum;
		logic commit;
		logic free_all;
	} ctl_t;

	// Datapath to controller status.
	typedef struct packed {
		cmd_t cmd;
		logic scan_done;
		logic found;
	} sts_t;

endpackage

/* rtl/core/bfsa_ctrl.sv */
// Sequencing state machine for the slot allocator.
module bfsa_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	output logic           done,
	output bfsa_pkg::ctl_t ctl,
	input  bfsa_pkg::sts_t sts
);
	import bfsa_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE     = 8'b0000_0001,
		S_DISPATCH = 8'b0000_0010,
		S_SCAN     = 8'b0000_0100,
		S_FETCH    = 8'b0000_1000,
		S_GRANT    = 8'b0001_0000,
		S_SUM      = 8'b0010_0000,
		S_COMMIT   = 8'b0100_0000,
		S_DONE     = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					state_d  = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (sts.cmd)
					CMD_ALLOC, CMD_RELEASE: state_d = S_SCAN;
					CMD_FREE_ALL: begin
						ctl.free_all = 1'b1;
						state_d      = S_DONE;
					end
					default: state_d = S_DONE;
				endcase
			end
			S_SCAN: begin
				ctl.scan = 1'b1;
				if (sts.scan_done) begin
					if (sts.cmd != CMD_ALLOC) begin
						state_d = S_DONE;
					end else if (sts.found) begin
						state_d = S_FETCH;
					end else begin
						state_d = S_SUM;
					end
				end
			end
			S_FETCH: begin
				ctl.fetch = 1'b1;
				state_d   = S_GRANT;
			end
			S_GRANT: begin
				ctl.grant = 1'b1;
				state_d   = S_DONE;
			end
			S_SUM: begin
				ctl.sum = 1'b1;
				state_d = S_COMMIT;
			end
			S_COMMIT: begin
				ctl.commit = 1'b1;
				state_d    = S_DONE;
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

endmodule

/* rtl/core/bfsa_dp.sv */
// Slot tables, best-fit scan pipeline and bump-pointer arithmetic.
module bfsa_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bfsa_pkg::req_t                req,
	input  logic                          cfg_we,
	input  logic [bfsa_pkg::BYTE_W-1:0]   cfg_wdata,
	input  bfsa_pkg::ctl_t                ctl,
	output bfsa_pkg::sts_t                sts,
	output bfsa_pkg::rsp_t                rsp
);
	import bfsa_pkg::*;

	logic [BYTE_W-1:0] start_mem [MAX_SLOTS];
	logic [BYTE_W-1:0] len_mem   [MAX_SLOTS];
	logic [OP_W-1:0]   op_mem    [MAX_SLOTS];

	logic [MAX_SLOTS-1:0] busy_q;
	logic [CNT_W-1:0]     count_q;
	logic [BYTE_W-1:0]    bump_q, peak_q, cap_q;

	cmd_t              cmd_q;
	logic [SIZE_W-1:0] size_q;
	logic [OP_W-1:0]   op_q;

	logic [CNT_W-1:0]  scan_idx_q;
	logic              valid_s1;
	logic [SLOT_W-1:0] idx_s1;
	logic [BYTE_W-1:0] len_rd_s1, start_rd_s1;
	logic [OP_W-1:0]   op_rd_s1;
	logic              found_q;
	logic [SLOT_W-1:0] best_q;
	logic [BYTE_W-1:0] best_len_q;
	logic [SUM_W-1:0]  sum_q;

	status_t           st_q;
	logic [BYTE_W-1:0] off_q;
	logic [NUM_W-1:0]  num_q;
	logic              reused_q;

	logic              issue_en;
	logic [SLOT_W-1:0] rd_addr;
	logic [SLOT_W-1:0] wr_addr;
	logic              oom, full, carve;
	logic              fit, release_hit;
	logic [SIZE_W-1:0] size_rounded;

	assign issue_en = ctl.scan && (scan_idx_q < count_q);
	assign rd_addr  = ctl.fetch ? best_q : scan_idx_q[SLOT_W-1:0];
	assign wr_addr  = ctl.grant ? best_q : count_q[SLOT_W-1:0];

	// Round the request up to the next 256-byte boundary, keeping the carry.
	assign size_rounded = (SIZE_W'(req.request_bytes) + SIZE_W'(255))
		& ~SIZE_W'(255);

	assign oom   = sum_q > SUM_W'(cap_q);
	assign full  = count_q >= CNT_W'(MAX_SLOTS);
	assign carve = ctl.commit && !oom && !full;

	assign fit = valid_s1 && !busy_q[idx_s1]
		&& (SIZE_W'(len_rd_s1) >= size_q)
		&& (!found_q || (len_rd_s1 < best_len_q));
	assign release_hit = valid_s1 && busy_q[idx_s1] && (op_rd_s1 <= op_q);

	// Table storage: one write port, one registered read port each.
	always_ff @(posedge clk) begin
		if (carve) begin
			start_mem[wr_addr] <= bump_q;
			len_mem[wr_addr]   <= size_q[BYTE_W-1:0];
		end
		if (carve || ctl.grant) begin
			op_mem[wr_addr] <= op_q;
		end
		start_rd_s1 <= start_mem[rd_addr];
		len_rd_s1   <= len_mem[rd_addr];
		op_rd_s1    <= op_mem[rd_addr];
	end

	// Request payload and scan tracking.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q  <= req.command;
			size_q <= size_rounded;
			op_q   <= req.operation_id;
		end
		idx_s1 <= scan_idx_q[SLOT_W-1:0];
		if (fit) begin
			best_q     <= idx_s1;
			best_len_q <= len_rd_s1;
		end
		if (ctl.sum) begin
			sum_q <= SUM_W'(bump_q) + SUM_W'(size_q);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			st_q     <= ST_OK;
			off_q    <= '0;
			num_q    <= '0;
			reused_q <= 1'b0;
		end else if (ctl.grant) begin
			off_q    <= start_rd_s1;
			num_q    <= NUM_W'(best_q);
			reused_q <= 1'b1;
		end else if (ctl.commit) begin
			if (oom) begin
				st_q <= ST_OOM;
			end else if (full) begin
				st_q <= ST_FULL;
			end else begin
				off_q <= bump_q;
				num_q <= NUM_W'(count_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= '0;
			count_q    <= '0;
			bump_q     <= '0;
			peak_q     <= '0;
			cap_q      <= '0;
			scan_idx_q <= '0;
			valid_s1   <= 1'b0;
			found_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (ctl.load) begin
				scan_idx_q <= '0;
				valid_s1   <= 1'b0;
				found_q    <= 1'b0;
			end else begin
				if (issue_en) begin
					scan_idx_q <= scan_idx_q + CNT_W'(1);
				end
				valid_s1 <= issue_en;
				if (cmd_q == CMD_ALLOC && fit) begin
					found_q <= 1'b1;
				end
			end
			// Drop busy on completed slots during a release scan.
			if (cmd_q == CMD_RELEASE && release_hit) begin
				busy_q[idx_s1] <= 1'b0;
			end
			if (ctl.free_all) begin
				busy_q <= '0;
			end
			if (ctl.grant) begin
				busy_q[best_q] <= 1'b1;
			end
			if (carve) begin
				busy_q[count_q[SLOT_W-1:0]] <= 1'b1;
				count_q <= count_q + CNT_W'(1);
				bump_q  <= sum_q[BYTE_W-1:0];
				if (sum_q[BYTE_W-1:0] > peak_q) begin
					peak_q <= sum_q[BYTE_W-1:0];
				end
			end
		end
	end

	assign sts.cmd       = cmd_q;
	assign sts.scan_done = !issue_en && !valid_s1;
	assign sts.found     = found_q;

	assign rsp.status      = st_q;
	assign rsp.slot_offset = off_q;
	assign rsp.slot_number = num_q;
	assign rsp.was_reused  = reused_q;
	assign rsp.bytes_used  = bump_q;
	assign rsp.bytes_peak  = peak_q;

endmodule

/* rtl/core/best_fit_slot_allocator_unit.sv */
// Top level of the best-fit slot allocator: controller plus datapath.
//
// Usage: drive req and raise start while busy is low; the request is taken
// at that clock edge. Commands: allocate (best-fit reuse, else carve at the
// bump pointer), release by op id, free all. Exactly one result follows per
// request: rsp is valid for the single cycle in which done is high, and
// busy drops in the cycle after that.
// An allocate scans the slot table, then reuses the best fit (fetch, grant)
// or carves a new slot (sum, commit); a release scans the table; free-all
// and the unused command go from dispatch straight to done. The scan reads
// one slot entry per cycle from the slot tables' single read port.
// One request is in flight at a time; start is ignored while busy.
// Configuration: cfg_we with cfg_wdata loads the pool capacity; write it
// only while busy is low.
// Reset (arst_n low): all slots free, slot count, bump and peak pointers
// and capacity cleared; no clearing pass is needed.
// The receiver cannot stall: done is a one-cycle strobe.
module best_fit_slot_allocator_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  bfsa_pkg::req_t              req,
	output logic                        done,
	output bfsa_pkg::rsp_t              rsp,
	input  logic                        cfg_we,
	input  logic [bfsa_pkg::BYTE_W-1:0] cfg_wdata
);
	import bfsa_pkg::*;

	ctl_t ctl;
	sts_t sts;

	bfsa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.ctl    (ctl),
		.sts    (sts)
	);

	bfsa_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.ctl       (ctl),
		.sts       (sts),
		.rsp       (rsp)
	);

endmodule
